// ----- hw/rtl/pse_pkg.sv -----
package pse_pkg;

    // Default stack depth
    localparam int PSE_STACK_DEPTH = 64;

    // Iterations of the divider, one quotient bit each
    localparam int PSE_DIV_STEPS = 32;

    // Saturation limits of a Q16.16 word
    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    // Opcodes
    localparam logic [2:0] FN_LDC = 3'd0;
    localparam logic [2:0] FN_LDV = 3'd1;
    localparam logic [2:0] FN_ADD = 3'd2;
    localparam logic [2:0] FN_SUB = 3'd3;
    localparam logic [2:0] FN_MUL = 3'd4;
    localparam logic [2:0] FN_DIV = 3'd5;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DIV0  = 2'd1;
    localparam logic [1:0] ST_UNBAL = 2'd2;
    localparam logic [1:0] ST_FLOW  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_VAR_A = 2'd0;
    localparam logic [1:0] CFG_VAR_B = 2'd1;
    localparam logic [1:0] CFG_VAR_C = 2'd2;
    localparam logic [1:0] CFG_VAR_D = 2'd3;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] immediate;
        logic [1:0]         var_select;
        logic               is_last;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [1:0]         status;
    } t_out_item;

    typedef enum logic [1:0] {
        RS_ADDSUB,
        RS_MUL,
        RS_DIV
    } t_res_sel;

    // Controller to datapath commands
    typedef struct packed {
        logic       latch_item;
        logic       push;
        logic       set_err;
        logic [1:0] err_val;
        logic       rd_opnd;
        logic       mul_start;
        logic       div_start;
        logic       wr_result;
        t_res_sel   res_sel;
        logic       finish;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [2:0] func;
        logic       is_last;
        logic       err_active;
        logic       sp_ge2;
        logic       sp_full;
        logic       tos_zero;
        logic       div_done;
        logic       out_full;
    } t_dp_stat;

endpackage

// ----- hw/rtl/pse_div.sv -----
module pse_div import pse_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_dividend,
    input  logic signed [31:0] i_divisor,
    output logic               o_done,
    output logic signed [31:0] o_quot
);

    localparam int CW = $clog2(PSE_DIV_STEPS);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic          r_neg;
    logic          r_sat;
    logic [31:0]   r_den;
    logic [31:0]   r_rem;
    logic [31:0]   r_num;
    logic [31:0]   r_q;

    logic [31:0] ua;
    logic [31:0] ub;
    logic        sat_chk;
    logic [32:0] rem2;
    logic        ge;
    logic [31:0] n_rem;

    // Magnitudes and early saturation check on the shifted dividend
    always_comb begin
        ua      = i_dividend[31] ? 32'(-i_dividend) : i_dividend;
        ub      = i_divisor[31] ? 32'(-i_divisor) : i_divisor;
        sat_chk = {16'd0, ua} >= {ub, 16'd0};
    end

    // One restoring step
    always_comb begin
        rem2  = {r_rem, r_num[31]};
        ge    = rem2 >= {1'b0, r_den};
        n_rem = ge ? 32'(rem2 - {1'b0, r_den}) : rem2[31:0];
    end

    // Sequence the iterations
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt  <= '0;
                r_busy <= !sat_chk;
                r_done <= sat_chk;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(PSE_DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Hold operands and partial results
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[31] ^ i_divisor[31];
            r_sat <= sat_chk;
            r_den <= ub;
            r_rem <= {16'd0, ua[31:16]};
            r_num <= {ua[15:0], 16'd0};
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_num <= {r_num[30:0], 1'b0};
            r_q   <= {r_q[30:0], ge};
        end
    end

    // Apply sign and saturate
    always_comb begin
        if (r_sat) begin
            o_quot = r_neg ? Q_MIN : Q_MAX;
        end else if (!r_neg) begin
            o_quot = r_q[31] ? Q_MAX : r_q;
        end else if (r_q[31] && (|r_q[30:0])) begin
            o_quot = Q_MIN;
        end else begin
            o_quot = 32'(32'd0 - r_q);
        end
    end

    assign o_done = r_done;

endmodule

// ----- hw/rtl/pse_dp.sv -----
module pse_dp import pse_pkg::*; #(
    parameter int STACK_DEPTH = PSE_STACK_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_in_item    i_in_data,
    input  logic        i_cfg_valid,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data
);

    localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SPW = $clog2(STACK_DEPTH + 1);

    t_in_item           r_item;
    logic signed [31:0] r_var [4];
    logic [SPW-1:0]     r_sp;
    logic [1:0]         r_err;
    logic signed [31:0] r_tos;
    logic signed [31:0] r_mem [STACK_DEPTH];
    logic signed [31:0] r_rdata;
    logic signed [63:0] r_prod;
    logic               r_out_valid;
    t_out_item          r_out_data;

    logic signed [31:0] push_val;
    logic signed [32:0] sum;
    logic signed [31:0] addsub_res;
    logic signed [31:0] mul_res;
    logic signed [31:0] div_res;
    logic signed [31:0] res;
    logic [SPW-1:0]     sp_m1;
    logic [SPW-1:0]     sp_m2;
    logic               div_done;
    t_out_item          fin_data;

    pse_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_rdata),
        .i_divisor  (r_tos),
        .o_done     (div_done),
        .o_quot     (div_res)
    );

    assign sp_m1 = r_sp - 1'b1;
    assign sp_m2 = r_sp - SPW'(2);

    // Select the pushed value
    assign push_val = (r_item.func == FN_LDV) ? r_var[r_item.var_select] : r_item.immediate;

    // Saturating add and subtract
    always_comb begin
        if (r_item.func == FN_SUB) begin
            sum = {r_rdata[31], r_rdata} - {r_tos[31], r_tos};
        end else begin
            sum = {r_rdata[31], r_rdata} + {r_tos[31], r_tos};
        end
        if (sum[32] != sum[31]) begin
            addsub_res = sum[32] ? Q_MIN : Q_MAX;
        end else begin
            addsub_res = sum[31:0];
        end
    end

    // Shift product down by the fraction bits and saturate
    always_comb begin
        if ((&r_prod[63:47]) || !(|r_prod[63:47])) begin
            mul_res = r_prod[47:16];
        end else begin
            mul_res = r_prod[63] ? Q_MIN : Q_MAX;
        end
    end

    always_comb begin
        case (i_cmd.res_sel)
            RS_MUL:  res = mul_res;
            RS_DIV:  res = div_res;
            default: res = addsub_res;
        endcase
    end

    // Final answer of an expression
    always_comb begin
        if (r_err != ST_OK) begin
            fin_data = '{result_value: 32'sd0, status: r_err};
        end else if (r_sp != SPW'(1)) begin
            fin_data = '{result_value: 32'sd0, status: ST_UNBAL};
        end else begin
            fin_data = '{result_value: r_tos, status: ST_OK};
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_var[i] <= '0;
            end
        end else if (i_cfg_valid) begin
            r_var[i_cfg_index] <= i_cfg_data;
        end
    end

    // Stack pointer and sticky error
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp  <= '0;
            r_err <= ST_OK;
        end else if (i_cmd.finish) begin
            r_sp  <= '0;
            r_err <= ST_OK;
        end else begin
            if (i_cmd.push) begin
                r_sp <= r_sp + 1'b1;
            end else if (i_cmd.wr_result) begin
                r_sp <= sp_m1;
            end
            if (i_cmd.set_err) begin
                r_err <= i_cmd.err_val;
            end
        end
    end

    // Item, top of stack and product
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_item) begin
            r_item <= i_in_data;
        end
        if (i_cmd.push) begin
            r_tos <= push_val;
        end else if (i_cmd.wr_result) begin
            r_tos <= res;
        end
        if (i_cmd.mul_start) begin
            r_prod <= 64'(r_rdata) * 64'(r_tos);
        end
    end

    // Stack memory below the top entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && (r_sp != '0)) begin
            r_mem[sp_m1[AW-1:0]] <= r_tos;
        end
        if (i_cmd.rd_opnd) begin
            r_rdata <= r_mem[sp_m2[AW-1:0]];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_data <= fin_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        o_stat.func       = r_item.func;
        o_stat.is_last    = r_item.is_last;
        o_stat.err_active = r_err != ST_OK;
        o_stat.sp_ge2     = r_sp >= SPW'(2);
        o_stat.sp_full    = r_sp == SPW'(STACK_DEPTH);
        o_stat.tos_zero   = r_tos == 32'sd0;
        o_stat.div_done   = div_done;
        o_stat.out_full   = r_out_valid;
    end

endmodule

// ----- hw/rtl/pse_ctrl.sv -----
module pse_ctrl import pse_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_OPND,
        S_MULW,
        S_DIVW,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch_item = 1'b1;
                    n_state          = S_EXEC;
                end
            end
            S_EXEC: begin
                // Skip everything after the first error
                n_state = S_FIN;
                if (!i_stat.err_active) begin
                    case (i_stat.func)
                        FN_LDC, FN_LDV: begin
                            if (i_stat.sp_full) begin
                                o_cmd.set_err = 1'b1;
                                o_cmd.err_val = ST_FLOW;
                            end else begin
                                o_cmd.push = 1'b1;
                            end
                        end
                        FN_ADD, FN_SUB, FN_MUL, FN_DIV: begin
                            if (!i_stat.sp_ge2) begin
                                o_cmd.set_err = 1'b1;
                                o_cmd.err_val = ST_FLOW;
                            end else if ((i_stat.func == FN_DIV) && i_stat.tos_zero) begin
                                o_cmd.set_err = 1'b1;
                                o_cmd.err_val = ST_DIV0;
                            end else begin
                                o_cmd.rd_opnd = 1'b1;
                                n_state       = S_OPND;
                            end
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_OPND: begin
                // Deeper operand is now registered
                case (i_stat.func)
                    FN_MUL: begin
                        o_cmd.mul_start = 1'b1;
                        n_state         = S_MULW;
                    end
                    FN_DIV: begin
                        o_cmd.div_start = 1'b1;
                        n_state         = S_DIVW;
                    end
                    default: begin
                        o_cmd.wr_result = 1'b1;
                        o_cmd.res_sel   = RS_ADDSUB;
                        n_state         = S_FIN;
                    end
                endcase
            end
            S_MULW: begin
                o_cmd.wr_result = 1'b1;
                o_cmd.res_sel   = RS_MUL;
                n_state         = S_FIN;
            end
            S_DIVW: begin
                if (i_stat.div_done) begin
                    o_cmd.wr_result = 1'b1;
                    o_cmd.res_sel   = RS_DIV;
                    n_state         = S_FIN;
                end
            end
            S_FIN: begin
                // Hold the last item until the output register is free
                if (!i_stat.is_last) begin
                    n_state = S_IDLE;
                end else if (!i_stat.out_full) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- hw/rtl/postfix_stack_evaluator_top.sv -----
// States per instruction: IDLE, EXEC, FIN, plus OPND for an error-free
// add/sub, OPND and MULW for mul, OPND and DIVW for div. DIVW waits for the
// divider, done at once if the quotient saturates early, else one quotient
// bit per cycle over 32 steps; FIN holds a last item until output is free.
// Synchronous active-low reset clears the stack pointer, error, variables
// and output valid; the stack memory itself is not cleared.
module postfix_stack_evaluator_top import pse_pkg::*; #(
    parameter int STACK_DEPTH = PSE_STACK_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    pse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pse_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTH
    // No result is pending right after reset
    a_rst_out : assert property (@(posedge i_clk) $rose(i_rst_n) |-> !o_out_valid)
        else $error("output valid after reset");

    // An error result carries a zero value
    a_err_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status != ST_OK)) |-> (o_out_data.result_value == 32'sd0))
        else $error("nonzero value with error status");

    // Divider finishes only while an item is in flight
    a_div_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.div_done |-> !o_in_ready)
        else $error("divider done while idle");

    // Push and pop never in the same cycle
    a_push_pop : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.push && cmd.wr_result))
        else $error("push and pop together");
`endif

endmodule

// ----- tb/sv/postfix_stack_evaluator_checker.sv -----
module postfix_stack_evaluator_checker import pse_pkg::*; #(
    parameter int STACK_DEPTH = PSE_STACK_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in_item    i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out_item   i_out_data,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    // Shadow copy of the evaluator state
    logic signed [31:0] var_file [4];
    logic signed [31:0] value_stack [STACK_DEPTH];
    int                 depth_count = 0;
    logic [1:0]         sticky_status = ST_OK;

    // Results still owed by the block, oldest first
    t_out_item          expected_results [$];
    int                 fail_count = 0;
    int                 pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    // Clamp a wide intermediate to the Q16.16 range
    function automatic logic signed [31:0] clamp_q(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return Q_MAX;
        if (v < -64'sd2147483648) return Q_MIN;
        return v[31:0];
    endfunction

    task automatic push_word(input logic signed [31:0] w);
        if (depth_count >= STACK_DEPTH) begin
            sticky_status = ST_FLOW;
        end else begin
            value_stack[depth_count] = w;
            depth_count++;
        end
    endtask

    // Pop two operands, combine them and push the saturated result
    task automatic apply_arith(input logic [2:0] fn);
        logic signed [63:0] lhs;
        logic signed [63:0] rhs;
        logic signed [63:0] wide;
        if (depth_count < 2) begin
            sticky_status = ST_FLOW;
            return;
        end
        rhs = value_stack[depth_count - 1];
        lhs = value_stack[depth_count - 2];
        if (fn == FN_DIV && rhs == 0) begin
            sticky_status = ST_DIV0;
            return;
        end
        case (fn)
            FN_ADD: wide = lhs + rhs;
            FN_SUB: wide = lhs - rhs;
            FN_MUL: wide = (lhs * rhs) >>> 16;
            default: wide = (lhs * 64'sd65536) / rhs;
        endcase
        depth_count--;
        value_stack[depth_count - 1] = clamp_q(wide);
    endtask

    // Execute one instruction; on the last one queue the answer and clear
    task automatic run_instruction(input t_in_item it);
        t_out_item answer;
        if (sticky_status == ST_OK) begin
            case (it.func)
                FN_LDC: push_word(it.immediate);
                FN_LDV: push_word(var_file[it.var_select]);
                FN_ADD, FN_SUB, FN_MUL, FN_DIV: apply_arith(it.func);
                default: ;
            endcase
        end
        if (it.is_last) begin
            answer.result_value = '0;
            if (sticky_status != ST_OK) begin
                answer.status = sticky_status;
            end else if (depth_count != 1) begin
                answer.status = ST_UNBAL;
            end else begin
                answer.status       = ST_OK;
                answer.result_value = value_stack[0];
            end
            expected_results.push_back(answer);
            depth_count   = 0;
            sticky_status = ST_OK;
        end
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (expected_results.size() == 0) begin
            $error("unexpected result: result_value %h status %0d",
                   got.result_value, got.status);
            fail_count++;
        end else begin
            want = expected_results.pop_front();
            if (got.result_value !== want.result_value) begin
                $error("result_value mismatch: expected %h, actual %h",
                       want.result_value, got.result_value);
                fail_count++;
            end
            if (got.status !== want.status) begin
                $error("status mismatch: expected %0d, actual %0d",
                       want.status, got.status);
                fail_count++;
            end
        end
    endtask

    // Track every transaction on the three channels
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            depth_count   = 0;
            sticky_status = ST_OK;
            foreach (var_file[k]) var_file[k] = '0;
            expected_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) check_result(i_out_data);
            if (i_cfg_valid && i_cfg_ready) var_file[i_cfg_index] = i_cfg_data;
            if (i_in_valid && i_in_ready) run_instruction(i_in_data);
        end
        pending_count = expected_results.size();
    end

endmodule

// ----- tb/sv/tb_postfix_stack_evaluator_top.sv -----
module tb_postfix_stack_evaluator_top;
    import pse_pkg::*;

    // Opcodes the block leaves unused
    localparam logic [2:0] FN_NOP6 = 3'd6;
    localparam logic [2:0] FN_NOP7 = 3'd7;

    // Idle cycles after the last result before touching the registers
    localparam int DRAIN_CYCLES = 60;
    localparam int PHASE_ITEMS  = 150;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_in_item    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_item   out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_VAR_A;
    logic [31:0] cfg_data = '0;
    int          fail_count;
    int          pending;

    logic        calm_mode = 1'b0;
    int          items_sent = 0;
    int          rdy_burst = 0;

    postfix_stack_evaluator_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    postfix_stack_evaluator_checker result_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Stall the result channel in random bursts, never in the calm phase
    always @(negedge clk) begin
        if (calm_mode) begin
            out_ready <= 1'b1;
            rdy_burst <= 0;
        end else if (rdy_burst == 0) begin
            out_ready <= ($urandom_range(0, 2) != 0);
            rdy_burst <= $urandom_range(1, 19);
        end else begin
            rdy_burst <= rdy_burst - 1;
        end
    end

    // Random Q16.16 operand, biased toward edges and small magnitudes
    function automatic logic [31:0] rand_q();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0, 1: v = $urandom;
            2, 3: v = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            4: begin
                case ($urandom_range(0, 4))
                    0: v = Q_MAX;
                    1: v = Q_MIN;
                    2: v = '0;
                    3: v = 32'hFFFF_FFFF;
                    default: v = 32'h0001_0000;
                endcase
            end
            default: v = ($urandom_range(0, 200) - 100) << 16;
        endcase
        return v;
    endfunction

    // Send one instruction transaction, with an optional idle burst ahead
    task automatic send_op(input logic [2:0] fn, input logic [31:0] imm,
                           input logic [1:0] sel, input logic last);
        t_in_item it;
        if (!calm_mode && $urandom_range(0, 3) == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        it.func       = fn;
        it.immediate  = imm;
        it.var_select = sel;
        it.is_last    = last;
        in_data  = it;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        cfg_index = idx;
        cfg_data  = value;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Hold the sender until every owed result has come back
    task automatic wait_results();
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic settle();
        wait_results();
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Emit a well-formed postfix expression with the given leaf count;
    // stack_all pushes every leaf before the first operator
    task automatic send_formula(input int leaves, input logic stack_all);
        int         depth;
        int         left;
        logic       last;
        logic [2:0] fn;
        depth = 0;
        left  = leaves;
        while (left > 0 || depth > 1) begin
            if (left > 0 && (depth < 2 || stack_all || $urandom_range(0, 1) == 1)) begin
                left--;
                depth++;
                last = (left == 0 && depth == 1);
                if ($urandom_range(0, 1) == 1)
                    send_op(FN_LDC, rand_q(), 2'($urandom), last);
                else
                    send_op(FN_LDV, $urandom, 2'($urandom), last);
            end else begin
                depth--;
                last = (left == 0 && depth == 1);
                case ($urandom_range(0, 3))
                    0: fn = FN_ADD;
                    1: fn = FN_SUB;
                    2: fn = FN_MUL;
                    default: fn = FN_DIV;
                endcase
                send_op(fn, $urandom, 2'($urandom), last);
            end
        end
    endtask

    // Short run of arbitrary instructions, unused opcodes included
    task automatic send_noise();
        int len;
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
            send_op(3'($urandom), $urandom, 2'($urandom), i == len - 1);
    endtask

    initial begin
        int pick;
        int phase_end;
        int leaves;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_reg(CFG_VAR_A, Q_MAX);
        write_reg(CFG_VAR_B, Q_MIN);
        write_reg(CFG_VAR_C, 32'h0000_0000);
        write_reg(CFG_VAR_D, 32'h0001_0000);

        // Saturating add, sub and mul
        send_op(FN_LDC, Q_MAX, 2'd0, 1'b0);
        send_op(FN_LDC, Q_MAX, 2'd0, 1'b0);
        send_op(FN_ADD, '0, 2'd0, 1'b1);
        send_op(FN_LDC, Q_MIN, 2'd0, 1'b0);
        send_op(FN_LDC, 32'h0000_0001, 2'd0, 1'b0);
        send_op(FN_SUB, '0, 2'd0, 1'b1);
        send_op(FN_LDC, Q_MAX, 2'd0, 1'b0);
        send_op(FN_LDC, Q_MIN, 2'd0, 1'b0);
        send_op(FN_MUL, '0, 2'd0, 1'b1);
        // Variables, and a plain divide by one
        send_op(FN_LDV, '0, 2'd0, 1'b0);
        send_op(FN_LDV, '0, 2'd3, 1'b0);
        send_op(FN_DIV, '0, 2'd0, 1'b1);
        // Divide by zero, and the push after it must be ignored
        send_op(FN_LDC, 32'h0005_0000, 2'd0, 1'b0);
        send_op(FN_LDV, '0, 2'd2, 1'b0);
        send_op(FN_DIV, '0, 2'd0, 1'b0);
        send_op(FN_LDC, 32'h0000_0001, 2'd0, 1'b1);
        // Operator on an empty stack
        send_op(FN_ADD, '0, 2'd0, 1'b1);
        // Two entries left over
        send_op(FN_LDC, 32'h0002_8000, 2'd0, 1'b0);
        send_op(FN_LDV, '0, 2'd1, 1'b1);
        // Unused opcodes end an empty expression
        send_op(FN_NOP6, '0, 2'd0, 1'b1);
        send_op(FN_NOP7, 32'hFFFF_FFFF, 2'd3, 1'b1);
        // Quotient that overflows the positive range
        send_op(FN_LDC, Q_MIN, 2'd0, 1'b0);
        send_op(FN_LDC, 32'hFFFF_FFFF, 2'd0, 1'b0);
        send_op(FN_DIV, '0, 2'd0, 1'b1);

        for (int ph = 1; ph <= 4; ph++) begin
            settle();
            case (ph)
                1: begin
                    write_reg(CFG_VAR_A, $urandom);
                    write_reg(CFG_VAR_B, $urandom);
                    write_reg(CFG_VAR_C, $urandom);
                    write_reg(CFG_VAR_D, $urandom);
                end
                2: begin
                    write_reg(CFG_VAR_A, Q_MIN);
                    write_reg(CFG_VAR_B, Q_MAX);
                    write_reg(CFG_VAR_C, 32'h0000_0000);
                    write_reg(CFG_VAR_D, 32'hFFFF_FFFF);
                end
                default: begin
                    write_reg(CFG_VAR_A, rand_q());
                    write_reg(CFG_VAR_B, rand_q());
                    write_reg(CFG_VAR_C, rand_q());
                    write_reg(CFG_VAR_D, rand_q());
                end
            endcase
            calm_mode = (ph == 4);
            phase_end = items_sent + PHASE_ITEMS;

            // Overflow the stack once, and fill it exactly once
            if (ph == 1) send_formula(65, 1'b1);
            if (ph == 2) send_formula(64, 1'b1);

            while (items_sent < phase_end) begin
                pick   = $urandom_range(0, 99);
                leaves = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16)
                                                      : $urandom_range(1, 6);
                if (pick < 72) begin
                    send_formula(leaves, 1'b0);
                end else if (pick < 94) begin
                    send_noise();
                end else begin
                    wait_results();
                    send_formula(leaves, 1'b0);
                end
            end
        end

        settle();
        if (fail_count == 0 && pending == 0)
            $display("tb_postfix_stack_evaluator_top passed");
        else
            $display("tb_postfix_stack_evaluator_top failed");
        $finish;
    end

    // Abort a hung run
    initial begin
        #4000000;
        $display("tb_postfix_stack_evaluator_top failed");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/pse_pkg.sv
hw/rtl/pse_div.sv
hw/rtl/pse_dp.sv
hw/rtl/pse_ctrl.sv
hw/rtl/postfix_stack_evaluator_top.sv
tb/sv/postfix_stack_evaluator_checker.sv
tb/sv/tb_postfix_stack_evaluator_top.sv
